// ===== rtl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg
// shared constants, types and helper functions of the glob matcher
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int NPOS        = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [7:0] STAR_CHAR   = 8'd42;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_END     = 2'd3
    } op_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic subject;
        logic finish;
    } wgm_cmd_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // star runs pass a set bit upward: a carry chain with generate s&m, propagate m
    function automatic logic [NPOS-1:0] close_set(input logic [NPOS-1:0] s,
                                                  input logic [NPOS-1:0] m);
        logic [NPOS-1:0] t;
        logic [NPOS-1:0] carry;
        t     = s & m;
        carry = (t + m) ^ t ^ m;
        return s | carry;
    endfunction

endpackage

// ===== rtl/wgm_pattern_store.sv =====
// ----------------------------------------------------------------------------
// wgm_pattern_store
// pattern character store with length, star mask and per-position compare
// ----------------------------------------------------------------------------
module wgm_pattern_store
    import wgm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wgm_cmd_t               cmd,
    input  logic [7:0]             ch,
    input  logic [7:0]             fc,
    output logic [MAX_PATTERN-1:0] star_mask,
    output logic [MAX_PATTERN-1:0] star_mask_next,
    output logic [MAX_PATTERN-1:0] hit_mask,
    output logic [LEN_W-1:0]       len,
    output logic                   overflow
);

    logic [7:0]             store_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [MAX_PATTERN-1:0] used_reg;
    logic [MAX_PATTERN-1:0] used_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   room;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;

    assign room   = len_reg < LEN_W'(MAX_PATTERN);
    assign wr_en  = cmd.append && room;
    assign wr_idx = len_reg[IDX_W-1:0];

    always_comb
    begin
        star_mask_next = star_reg;
        used_next      = used_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        if (cmd.clear)
        begin
            star_mask_next = '0;
            used_next      = '0;
            len_next       = '0;
            ovf_next       = 1'b0;
        end
        else if (cmd.append)
        begin
            if (room)
            begin
                star_mask_next[wr_idx] = (ch == STAR_CHAR);
                used_next[wr_idx]      = 1'b1;
                len_next               = len_reg + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_reg <= '0;
            used_reg <= '0;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            star_reg <= star_mask_next;
            used_reg <= used_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_idx] <= fold_case(ch);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            hit_mask[i] = used_reg[i] && !star_reg[i] && (store_reg[i] == fc);
        end
    end

    assign star_mask = star_reg;
    assign len       = len_reg;
    assign overflow  = ovf_reg;

endmodule

// ===== rtl/wgm_match_core.sv =====
// ----------------------------------------------------------------------------
// wgm_match_core
// active position set, subject star flag and verdict
// ----------------------------------------------------------------------------
module wgm_match_core
    import wgm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  wgm_cmd_t               cmd,
    input  logic [7:0]             ch,
    input  logic [MAX_PATTERN-1:0] star_mask,
    input  logic [MAX_PATTERN-1:0] star_mask_next,
    input  logic [MAX_PATTERN-1:0] hit_mask,
    input  logic [LEN_W-1:0]       len,
    output logic                   matched
);

    logic [NPOS-1:0] active_reg;
    logic [NPOS-1:0] active_next;
    logic            has_star_reg;
    logic            has_star_next;
    logic [NPOS-1:0] m_cur;
    logic [NPOS-1:0] m_new;
    logic [NPOS-1:0] restart;
    logic [NPOS-1:0] step;

    assign m_cur   = {1'b0, star_mask};
    assign m_new   = {1'b0, star_mask_next};
    assign restart = close_set(NPOS'(1), m_new);
    assign step    = (active_reg & m_cur) | ((active_reg & {1'b0, hit_mask}) << 1);

    always_comb
    begin
        active_next   = active_reg;
        has_star_next = has_star_reg;
        if (cmd.clear || cmd.append || cmd.finish)
        begin
            active_next   = restart;
            has_star_next = 1'b0;
        end
        else if (cmd.subject)
        begin
            active_next   = close_set(step, m_cur);
            has_star_next = has_star_reg || (ch == STAR_CHAR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= NPOS'(1);
            has_star_reg <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            has_star_reg <= has_star_next;
        end
    end

    assign matched = active_reg[len] && !has_star_reg;

endmodule

// ===== rtl/wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// star-only glob match of a streamed subject against a loaded pattern
// ----------------------------------------------------------------------------
// path: an end-of-subject beat passes the input register, then the verdict register
// throughput: one beat per cycle while no end-of-subject beat stalls, set by the position set update
// a verdict waiting on m_tready stalls only a following end-of-subject beat
// reset: empty pattern, overflow clear, active set at position zero, no beats
// held
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch
    input  logic [1:0] s_tuser,   // op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // matched, overflow, zero pad
);

    logic                   in_valid_reg;
    op_t                    op_reg;
    logic [7:0]             ch_reg;
    logic                   out_valid_reg;
    logic                   matched_reg;
    logic                   overflow_reg;
    logic                   stall;
    logic                   fire;
    wgm_cmd_t               cmd;
    logic [7:0]             fc;
    logic [MAX_PATTERN-1:0] star_mask;
    logic [MAX_PATTERN-1:0] star_mask_next;
    logic [MAX_PATTERN-1:0] hit_mask;
    logic [LEN_W-1:0]       len;
    logic                   overflow;
    logic                   matched;

    assign stall    = in_valid_reg && (op_reg == OP_END) && out_valid_reg && !m_tready;
    assign fire     = in_valid_reg && !stall;
    assign s_tready = !in_valid_reg || !stall;

    assign cmd.clear   = fire && (op_reg == OP_CLEAR);
    assign cmd.append  = fire && (op_reg == OP_APPEND);
    assign cmd.subject = fire && (op_reg == OP_SUBJECT);
    assign cmd.finish  = fire && (op_reg == OP_END);
    assign fc          = fold_case(ch_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= op_t'(s_tuser);
            ch_reg <= s_tdata;
        end
        if (cmd.finish)
        begin
            matched_reg  <= matched;
            overflow_reg <= overflow;
        end
    end

    wgm_pattern_store u_store (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .ch             (ch_reg),
        .fc             (fc),
        .star_mask      (star_mask),
        .star_mask_next (star_mask_next),
        .hit_mask       (hit_mask),
        .len            (len),
        .overflow       (overflow)
    );

    wgm_match_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .ch             (ch_reg),
        .star_mask      (star_mask),
        .star_mask_next (star_mask_next),
        .hit_mask       (hit_mask),
        .len            (len),
        .matched        (matched)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, overflow_reg, matched_reg};

`ifndef SYNTHESIS
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire && (op_reg == OP_END)))
        else $error("verdict beat without end of subject");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> in_valid_reg && $stable(ch_reg) && (op_reg == OP_END))
        else $error("stalled end of subject lost");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_star_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (star_mask == '0) && !overflow)
        else $error("clear left pattern state behind");
`endif

endmodule

// ===== tb/wgm_checker.sv =====
// ----------------------------------------------------------------------------
// wgm_checker
// watches both stream channels of the glob matcher, predicts each verdict
// from the accepted command beats and compares it with the verdict beats
// ----------------------------------------------------------------------------
module wgm_checker
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // ch
    input  logic [1:0] s_tuser,   // op
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // matched, overflow, zero pad
    output int         fails,
    output int         pending,
    output int         verdicts,
    output int         hits,
    output int         overflows
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    verdict_t        verdict_q[$];
    logic [7:0]      glob_chars [MAX_PATTERN];
    int              glob_len;
    logic [NPOS-1:0] live_pos;
    logic            subj_star;
    logic            glob_ovf;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // a live star position also makes the position after it live
    function automatic logic [NPOS-1:0] star_closure(input logic [NPOS-1:0] s);
        logic [NPOS-1:0] r;
        r = s;
        for (int i = 0; i < glob_len; i++)
        begin
            if (r[i] && glob_chars[i] == STAR_CHAR)
            begin
                r[i + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [NPOS-1:0] advance(input logic [7:0] ch);
        logic [NPOS-1:0] nxt;
        nxt = '0;
        for (int i = 0; i < glob_len; i++)
        begin
            if (live_pos[i])
            begin
                if (glob_chars[i] == STAR_CHAR)
                begin
                    nxt[i] = 1'b1;
                end
                else if (to_upper(glob_chars[i]) == to_upper(ch))
                begin
                    nxt[i + 1] = 1'b1;
                end
            end
        end
        return star_closure(nxt);
    endfunction

    task automatic restart_subject();
        live_pos  = star_closure(NPOS'(1));
        subj_star = 1'b0;
    endtask

    task automatic take_beat(input op_t op, input logic [7:0] ch);
        verdict_t v;
        case (op)
            OP_CLEAR:
            begin
                glob_len = 0;
                glob_ovf = 1'b0;
                restart_subject();
            end
            OP_APPEND:
            begin
                if (glob_len < MAX_PATTERN)
                begin
                    glob_chars[glob_len] = ch;
                    glob_len++;
                end
                else
                begin
                    glob_ovf = 1'b1;
                end
                restart_subject();
            end
            OP_SUBJECT:
            begin
                if (ch == STAR_CHAR)
                begin
                    subj_star = 1'b1;
                end
                live_pos = advance(ch);
            end
            default:
            begin
                v.matched  = live_pos[glob_len] && !subj_star;
                v.overflow = glob_ovf;
                verdict_q.push_back(v);
                restart_subject();
            end
        endcase
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            $error("verdict beat 0x%02h with no verdict expected", m_tdata);
            fails++;
            return;
        end
        want = verdict_q.pop_front();
        verdicts++;
        hits      += want.matched;
        overflows += want.overflow;
        if (m_tdata[0] !== want.matched)
        begin
            $error("matched: expected %0b, actual %0b", want.matched, m_tdata[0]);
            fails++;
        end
        if (m_tdata[1] !== want.overflow)
        begin
            $error("overflow: expected %0b, actual %0b", want.overflow, m_tdata[1]);
            fails++;
        end
        if (m_tdata[7:2] !== 6'd0)
        begin
            $error("pad: expected 0, actual %0h", m_tdata[7:2]);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_q.delete();
            glob_len  = 0;
            glob_ovf  = 1'b0;
            restart_subject();
            fails     = 0;
            verdicts  = 0;
            hits      = 0;
            overflows = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_verdict();
            end
            if (s_tvalid && s_tready)
            begin
                take_beat(op_t'(s_tuser), s_tdata);
            end
        end
        pending = verdict_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives pattern loads and subject strings into the glob matcher with random
// gaps and back-pressure; the checker predicts and compares every verdict
// ----------------------------------------------------------------------------
module tb
    import wgm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BEATS = 1125;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // ch
    logic [1:0] s_tuser  = 2'd0;   // op
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // matched, overflow, zero pad

    int fails;
    int pending;
    int verdicts;
    int hits;
    int overflows;

    int sent          = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 65;

    logic [7:0] glob_q[$];

    wildcard_glob_matcher i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wgm_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fails     (fails),
        .pending   (pending),
        .verdicts  (verdicts),
        .hits      (hits),
        .overflows (overflows)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // called right after a rising edge; returns at the edge that takes the beat
    task automatic send_beat(input op_t op, input logic [7:0] ch);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(negedge clk);
        while (!s_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] letter_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7)
        begin
            c = 8'd97 + 8'($urandom_range(0, 2));
            if ($urandom_range(0, 1) != 0)
            begin
                c = c ^ 8'h20;
            end
        end
        else
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] glob_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
        begin
            return STAR_CHAR;
        end
        return letter_char();
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= 8'd65 && c <= 8'd90) || (c >= LOWER_A && c <= LOWER_Z))
            && $urandom_range(0, 1) != 0)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // mostly a subject built to fit the pattern, sometimes spoiled or random
    task automatic send_subject();
        logic [7:0] subj[$];
        int         pos;
        int         cut;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(0, 6))
            begin
                subj.push_back(letter_char());
            end
        end
        else
        begin
            foreach (glob_q[k])
            begin
                if (glob_q[k] == STAR_CHAR)
                begin
                    repeat ($urandom_range(0, 3))
                    begin
                        subj.push_back(letter_char());
                    end
                end
                else
                begin
                    subj.push_back(flip_case(glob_q[k]));
                end
            end
            if ($urandom_range(0, 99) < 25)
            begin
                pos = $urandom_range(0, subj.size());
                case ($urandom_range(0, 2))
                    0: subj.insert(pos, STAR_CHAR);
                    1: if (pos < subj.size()) subj.delete(pos);
                    default: if (pos < subj.size()) subj[pos] = 8'($urandom_range(0, 255));
                endcase
            end
        end
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, subj.size()) : -1;
        foreach (subj[k])
        begin
            if (k == cut)
            begin
                glob_q.push_back(glob_char());
                send_beat(OP_APPEND, glob_q[$]);
            end
            send_beat(OP_SUBJECT, subj[k]);
        end
        send_beat(OP_END, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int  phase;
        int  glen;
        bit  fresh;
        phase = 0;
        fresh = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern against empty and non-empty subject
        send_beat(OP_END, 8'h00);
        send_beat(OP_SUBJECT, 8'h61);
        send_beat(OP_END, 8'hFF);
        // case folding, star over a run, zero byte as a plain character
        send_beat(OP_CLEAR, 8'hFF);
        send_beat(OP_APPEND, 8'h68);
        send_beat(OP_APPEND, STAR_CHAR);
        send_beat(OP_APPEND, 8'h00);
        send_beat(OP_SUBJECT, 8'h48);
        send_beat(OP_SUBJECT, 8'h78);
        send_beat(OP_SUBJECT, 8'h79);
        send_beat(OP_SUBJECT, 8'h00);
        send_beat(OP_END, 8'h00);
        // star inside the subject never matches
        send_beat(OP_SUBJECT, 8'h68);
        send_beat(OP_SUBJECT, STAR_CHAR);
        send_beat(OP_SUBJECT, 8'h00);
        send_beat(OP_END, 8'h00);
        // append while a subject is in progress restarts it
        send_beat(OP_SUBJECT, 8'h68);
        send_beat(OP_APPEND, 8'hFF);
        send_beat(OP_SUBJECT, 8'h68);
        send_beat(OP_SUBJECT, 8'h00);
        send_beat(OP_SUBJECT, 8'hFF);
        send_beat(OP_END, 8'h55);
        // non-empty pattern against empty subject
        send_beat(OP_END, 8'hAA);

        while (sent < TOTAL_BEATS)
        begin
            if (phase == 0 && sent >= TOTAL_BEATS / 3)
            begin
                drain();
                phase         = 1;
                send_idle_pct = 65;
                recv_idle_pct = 20;
            end
            else if (phase == 1 && sent >= 2 * TOTAL_BEATS / 3)
            begin
                drain();
                phase         = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_beat(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
                fresh = 1'b1;
            end
            else
            begin
                if (fresh || glob_q.size() > 36 || $urandom_range(0, 4) != 0)
                begin
                    send_beat(OP_CLEAR, 8'($urandom_range(0, 255)));
                    glob_q.delete();
                    fresh = 1'b0;
                end
                glen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36)
                                                   : $urandom_range(0, 6);
                repeat (glen)
                begin
                    glob_q.push_back(glob_char());
                    send_beat(OP_APPEND, glob_q[$]);
                end
                repeat ($urandom_range(1, 4))
                begin
                    send_subject();
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("tb: %0d command beats sent in three gap and stall settings", sent);
        $display("tb: %0d verdicts checked, %0d matches, %0d with pattern overflow",
                 verdicts, hits, overflows);
        if (fails == 0 && pending == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
